// ===== rtl/obfr_pkg.sv =====
// Shared types and constants for the optical blink frame receiver.
package obfr_pkg;

    // Number of bits in one received frame
    localparam int FRAME_BITS = 32;
    localparam int COUNT_W    = 6;

    // Threshold register reset value
    localparam logic [15:0] THRESHOLD_RESET = 16'd65440;

    // Command codes
    localparam logic [1:0] CMD_ACTIVATE = 2'd0;
    localparam logic [1:0] CMD_BUTTON   = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    // Frame header codes
    localparam logic [3:0] HDR_TIME = 4'd1;
    localparam logic [3:0] HDR_DATE = 4'd2;

    // Operating modes
    typedef enum logic [1:0] {
        MODE_DISPLAY = 2'd0,
        MODE_WAIT    = 2'd1,
        MODE_RECORD  = 2'd2,
        MODE_IDLE    = 2'd3
    } t_mode;

    // Frame classification
    typedef enum logic [1:0] {
        KIND_TIME    = 2'd0,
        KIND_DATE    = 2'd1,
        KIND_UNKNOWN = 2'd2,
        KIND_BAD_SUM = 2'd3
    } t_kind;

    // Input transaction payload
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] sample;
    } t_in_item;

    // Decoded frame content
    typedef struct packed {
        logic [7:0] computed_checksum;
        logic [1:0] frame_kind;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [4:0] day;
        logic [3:0] month;
        logic [5:0] year_offset;
    } t_frame_info;

    // Output transaction payload
    typedef struct packed {
        logic [1:0]  mode_now;
        logic [15:0] stored_reading;
        logic        frame_done;
        logic [31:0] frame_word;
        logic [7:0]  computed_checksum;
        logic [1:0]  frame_kind;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [5:0]  year_offset;
    } t_out_item;

endpackage

// ===== rtl/obfr_frame_check.sv =====
// Checksum test and header decode of a completed frame.
module obfr_frame_check (
    input  logic                 i_done,
    input  logic [31:0]          i_word,
    output obfr_pkg::t_frame_info o_info
);
    import obfr_pkg::*;

    logic [7:0] w_sum;

    // Sum the upper three bytes modulo 256
    assign w_sum = i_word[31:24] + i_word[23:16] + i_word[15:8];

    // Classify and extract fields; everything stays zero without a frame
    always_comb begin
        o_info = '0;
        if (i_done) begin
            o_info.computed_checksum = w_sum;
            if (w_sum != i_word[7:0]) begin
                o_info.frame_kind = KIND_BAD_SUM;
            end else if (i_word[31:28] == HDR_TIME) begin
                o_info.frame_kind = KIND_TIME;
                o_info.hour       = i_word[15:11];
                o_info.minute     = i_word[21:16];
                o_info.second     = i_word[27:22];
            end else if (i_word[31:28] == HDR_DATE) begin
                o_info.frame_kind  = KIND_DATE;
                o_info.day         = i_word[27:23];
                o_info.month       = i_word[22:19];
                o_info.year_offset = i_word[18:13];
            end else begin
                o_info.frame_kind = KIND_UNKNOWN;
            end
        end
    end

endmodule

// ===== rtl/obfr_core.sv =====
// Mode control, bit shifter and result assembly of the frame receiver.
module obfr_core #(
    parameter int FRAME_BITS = obfr_pkg::FRAME_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  obfr_pkg::t_in_item i_item,
    input  logic [15:0]        i_threshold,
    output obfr_pkg::t_out_item o_result
);
    import obfr_pkg::*;

    t_mode              r_mode,  n_mode;
    logic [31:0]        r_word,  n_word;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [15:0]        r_level, n_level;
    logic               w_done;
    logic               w_one;
    t_frame_info        w_info;

    assign w_one = (i_item.sample < i_threshold);

    // Next state for one transaction
    always_comb begin
        n_mode  = r_mode;
        n_word  = r_word;
        n_count = r_count;
        n_level = r_level;
        w_done  = 1'b0;
        unique case (i_item.command)
            CMD_ACTIVATE: begin
                n_mode = MODE_DISPLAY;
            end
            CMD_BUTTON: begin
                if (r_mode == MODE_DISPLAY || r_mode == MODE_IDLE) begin
                    n_mode = MODE_WAIT;
                end else begin
                    n_mode = MODE_IDLE;
                end
            end
            CMD_TICK: begin
                unique case (r_mode)
                    MODE_DISPLAY: begin
                        n_level = i_item.sample;
                    end
                    MODE_WAIT: begin
                        n_level = i_item.sample;
                        if (w_one) begin
                            n_count = '0;
                            n_word  = '0;
                            n_mode  = MODE_RECORD;
                        end
                    end
                    MODE_RECORD: begin
                        n_level = i_item.sample;
                        n_word  = {r_word[30:0], w_one};
                        n_count = r_count + 1'b1;
                        if (n_count >= COUNT_W'(FRAME_BITS)) begin
                            n_mode = MODE_IDLE;
                            w_done = 1'b1;
                        end
                    end
                    MODE_IDLE: begin
                        // hold everything
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                // unused command: hold state
            end
        endcase
    end

    // Check the frame as it completes
    obfr_frame_check u_check (
        .i_done (w_done),
        .i_word (n_word),
        .o_info (w_info)
    );

    // Assemble the result from the post-step state
    always_comb begin
        o_result.mode_now          = n_mode;
        o_result.stored_reading    = n_level;
        o_result.frame_done        = w_done;
        o_result.frame_word        = n_word;
        o_result.computed_checksum = w_info.computed_checksum;
        o_result.frame_kind        = w_info.frame_kind;
        o_result.hour              = w_info.hour;
        o_result.minute            = w_info.minute;
        o_result.second            = w_info.second;
        o_result.day               = w_info.day;
        o_result.month             = w_info.month;
        o_result.year_offset       = w_info.year_offset;
    end

    // Advance state on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_DISPLAY;
            r_word  <= '0;
            r_count <= '0;
            r_level <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_word  <= n_word;
            r_count <= n_count;
            r_level <= n_level;
        end
    end

endmodule

// ===== rtl/optical_blink_frame_receiver.sv =====
// Optical blink frame receiver: registered input and result. Throughput one transaction
// per cycle while the output is not stalled; the state update, 32-bit shift, threshold
// compare and byte-sum check all sit between the input and result registers.
// Synchronous active-low reset returns to display mode with an empty shift
// register and count, last level 0, and threshold 65440; both stages empty.
module optical_blink_frame_receiver #(
    parameter int FRAME_BITS = obfr_pkg::FRAME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  obfr_pkg::t_in_item   i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output obfr_pkg::t_out_item  o_out_item,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_valid,
    input  logic [15:0]          i_cfg_data,
    output logic                 o_cfg_ready
);
    import obfr_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [15:0] r_threshold;
    logic        w_adv_out;
    logic        w_adv_in;
    logic        w_step;
    t_out_item   w_result;

    // Pipeline flow control
    assign w_adv_out  = !r_out_valid || !i_out_stall;
    assign w_adv_in   = !r_in_valid || w_adv_out;
    assign w_step     = r_in_valid && w_adv_out;
    assign o_in_stall = !w_adv_in;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    obfr_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (r_in_item),
        .i_threshold (r_threshold),
        .o_result    (w_result)
    );

    // Capture input transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv_in) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_in && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Hold results until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_data;
        end
    end

endmodule
